[rtl/core/u16u8_pkg.sv]
// Package: shared types for the UTF-16LE to UTF-8 converter.
`default_nettype none

package u16u8_pkg;

    localparam int unsigned MaxResults = 5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } u16u8_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } u16u8_out_t;

    typedef struct packed {
        logic [7:0] low_half;
        logic       low_half_held;
        logic [9:0] lead_bits;
        logic       lead_held;
    } u16u8_state_t;

    // Results of one request, byte 0 leaves first; term marks the last as terminator.
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [2:0]                 cnt;
        logic                       term;
    } u16u8_burst_t;

    localparam logic [7:0] Utf8Lead2 = 8'hc0;
    localparam logic [7:0] Utf8Lead3 = 8'he0;
    localparam logic [7:0] Utf8Lead4 = 8'hf0;
    localparam logic [7:0] Utf8Cont  = 8'h80;
    localparam logic [20:0] SuppBase = 21'h10000;

endpackage

`default_nettype wire

[rtl/core/utf16le_to_utf8_converter_unit.sv]
// Top level: UTF-16LE to UTF-8 converter with result buffer and output register.
`default_nettype none

// Takes one UTF-16LE byte per request and decodes it in the cycle it is accepted;
// the 0 to 5 resulting UTF-8 bytes go into a small result buffer and leave through
// a registered output, one byte per cycle while the receiver takes them. A new
// request is taken once the buffer holds at most the byte now moving to the
// output, so the output port sets the rate: ASCII text moves one input byte per
// cycle while the output does not stall, a unit of two or more UTF-8 bytes or a
// surrogate pair holds back the next request until only its last byte is left,
// and the terminator counts as one more result byte.
module utf16le_to_utf8_converter_unit (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire u16u8_pkg::u16u8_in_t s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output u16u8_pkg::u16u8_out_t  m_data
);
    import u16u8_pkg::*;

    u16u8_state_t state_reg, state_next;
    u16u8_state_t burst_new_state;
    u16u8_burst_t burst_reg, burst_next;
    u16u8_burst_t burst_new;
    u16u8_out_t   out_reg, out_next;
    logic         m_valid_reg, m_valid_next;
    logic         load_out;
    logic         accept;

    u16u8_decode u_decode (
        .state_cur (state_reg),
        .req       (s_data),
        .state_new (burst_new_state),
        .burst     (burst_new)
    );

    assign load_out = (burst_reg.cnt != 3'd0) && (!m_valid_reg || m_ready);
    assign s_ready  = (burst_reg.cnt == 3'd0) || ((burst_reg.cnt == 3'd1) && load_out);
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        burst_next   = burst_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next        = 1'b1;
            out_next.out_byte   = burst_reg.bytes[0];
            out_next.run_end    = (burst_reg.cnt == 3'd1);
            out_next.string_end = (burst_reg.cnt == 3'd1) && burst_reg.term;
            burst_next.bytes    = {8'h00, burst_reg.bytes[MaxResults-1:1]};
            burst_next.cnt      = burst_reg.cnt - 3'd1;
        end
        if (accept) begin
            state_next = burst_new_state;
            burst_next = burst_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            burst_reg.cnt <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            burst_reg.cnt <= burst_next.cnt;
            m_valid_reg   <= m_valid_next;
        end
        burst_reg.bytes <= burst_next.bytes;
        burst_reg.term  <= burst_next.term;
        out_reg         <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_reg.cnt <= 3'(MaxResults))
        else $error("result buffer count out of range");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.final_byte)
        |=> (!state_reg.low_half_held && !state_reg.lead_held))
        else $error("state not cleared after final byte");

    a_low_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.final_byte && !state_reg.low_half_held)
        |=> (state_reg.low_half_held && burst_reg.cnt == 3'd0))
        else $error("low byte not held or results produced");

    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.string_end) |-> m_data.run_end)
        else $error("terminator not last result of its request");
`endif

endmodule

`default_nettype wire

[rtl/core/u16u8_decode.sv]
// Decode: pairs bytes into code units and forms the UTF-8 bytes of one request.
`default_nettype none

module u16u8_decode (
    input  wire u16u8_pkg::u16u8_state_t state_cur,
    input  wire u16u8_pkg::u16u8_in_t    req,
    output u16u8_pkg::u16u8_state_t      state_new,
    output u16u8_pkg::u16u8_burst_t      burst
);
    import u16u8_pkg::*;

    logic [15:0] unit;
    logic [20:0] cp;
    logic        is_surr;
    logic        is_trail;
    logic        is_lead;

    assign unit     = {req.in_byte, state_cur.low_half};
    assign is_surr  = (unit[15:11] == 5'b11011);
    assign is_trail = is_surr && unit[10];
    assign is_lead  = is_surr && !unit[10];
    assign cp       = {1'b0, state_cur.lead_bits, unit[9:0]} + SuppBase;

    always_comb begin
        state_new = state_cur;
        burst     = '0;
        if (!state_cur.low_half_held) begin
            state_new.low_half      = req.in_byte;
            state_new.low_half_held = 1'b1;
        end else begin
            state_new.low_half      = '0;
            state_new.low_half_held = 1'b0;
            state_new.lead_held     = 1'b0;
            state_new.lead_bits     = '0;
            if (state_cur.lead_held && is_trail) begin
                burst.bytes[0] = Utf8Lead4 | {5'd0, cp[20:18]};
                burst.bytes[1] = Utf8Cont | {2'd0, cp[17:12]};
                burst.bytes[2] = Utf8Cont | {2'd0, cp[11:6]};
                burst.bytes[3] = Utf8Cont | {2'd0, cp[5:0]};
                burst.cnt      = 3'd4;
            end else if (!is_surr) begin
                if (unit[15:7] == 9'd0) begin
                    burst.bytes[0] = {1'b0, unit[6:0]};
                    burst.cnt      = 3'd1;
                end else if (unit[15:11] == 5'd0) begin
                    burst.bytes[0] = Utf8Lead2 | {3'd0, unit[10:6]};
                    burst.bytes[1] = Utf8Cont | {2'd0, unit[5:0]};
                    burst.cnt      = 3'd2;
                end else begin
                    burst.bytes[0] = Utf8Lead3 | {4'd0, unit[15:12]};
                    burst.bytes[1] = Utf8Cont | {2'd0, unit[11:6]};
                    burst.bytes[2] = Utf8Cont | {2'd0, unit[5:0]};
                    burst.cnt      = 3'd3;
                end
            end else if (is_lead) begin
                state_new.lead_bits = unit[9:0];
                state_new.lead_held = 1'b1;
            end
        end
        if (req.final_byte) begin
            // terminator byte is already zero in the cleared slot
            burst.cnt  = burst.cnt + 3'd1;
            burst.term = 1'b1;
            state_new  = '0;
        end
    end

endmodule

`default_nettype wire

[verif/utf16le_to_utf8_converter_unit_test.sv]
// Testbench for the UTF-16LE to UTF-8 converter: directed and random strings, self-checking.
`timescale 1ns / 1ps

module utf16le_to_utf8_converter_unit_test;
    import u16u8_pkg::*;

    localparam int unsigned RandomItems = 140;
    localparam int unsigned HoldCycles = 120;
    localparam int unsigned DrainCycles = 24;
    localparam int unsigned StallLimit = 1000;

    typedef struct packed {
        u16u8_in_t        req;
        logic             typed;
        logic [2:0]       n;
        logic [0:4][7:0]  utf8;
    } script_row_t;

    // request, typed expectation flag, result count, UTF-8 bytes in output order
    localparam script_row_t Script[27] = '{
        {8'h41, 1'b0, 1'b1, 3'd0, 40'h0},
        {8'h00, 1'b0, 1'b1, 3'd1, 40'h4100000000},
        {8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'h00, 1'b0, 1'b1, 3'd1, 40'h0000000000},
        {8'h80, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hff, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'h07, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'h08, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hd8, 1'b0, 1'b1, 3'd0, 40'h0},
        {8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hdc, 1'b0, 1'b1, 3'd4, 40'hf090808000},
        {8'hff, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hdb, 1'b0, 1'b1, 3'd0, 40'h0},
        {8'hff, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hdf, 1'b0, 1'b1, 3'd4, 40'hf48fbfbf00},
        {8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hdc, 1'b0, 1'b1, 3'd0, 40'h0},
        {8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hd8, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hff, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hff, 1'b0, 1'b1, 3'd3, 40'hefbfbf0000},
        {8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
        {8'hd8, 1'b1, 1'b1, 3'd1, 40'h0000000000},
        {8'h41, 1'b1, 1'b1, 3'd1, 40'h0000000000}
    };

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    u16u8_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    u16u8_out_t m_data;

    int unsigned tx_idle_pct = 10;
    int unsigned rx_idle_pct = 62;
    bit          squeeze_req = 1'b0;

    int unsigned bytes_sent = 0;
    int unsigned strings_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;

    logic [7:0] unit_low = '0;
    logic       unit_low_held = 1'b0;
    logic [9:0] lead_payload = '0;
    logic       lead_waiting = 1'b0;

    u16u8_out_t utf8_burst[$];
    u16u8_out_t utf8_expected[$];

    utf16le_to_utf8_converter_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic add_utf8(input logic [7:0] b, input logic term);
        u16u8_out_t r;
        r.out_byte = b;
        r.run_end = 1'b0;
        r.string_end = term;
        utf8_burst.push_back(r);
    endtask

    // Decodes one accepted byte into utf8_burst and advances the decoder state.
    task automatic transcode_byte(input u16u8_in_t req);
        logic [15:0] unit;
        logic [20:0] cp;
        logic        emit;
        logic        trail;
        logic        had_lead;
        utf8_burst.delete();
        emit = 1'b0;
        cp = '0;
        if (!unit_low_held) begin
            unit_low = req.in_byte;
            unit_low_held = 1'b1;
        end else begin
            unit = {req.in_byte, unit_low};
            unit_low = '0;
            unit_low_held = 1'b0;
            trail = (unit[15:10] == 6'b110111);
            had_lead = lead_waiting;
            lead_waiting = 1'b0;
            if (had_lead && trail) begin
                cp = {1'b0, lead_payload, unit[9:0]} + SuppBase;
                emit = 1'b1;
            end else if (unit[15:11] != 5'b11011) begin
                cp = {5'b0, unit};
                emit = 1'b1;
            end else if (!trail) begin
                lead_payload = unit[9:0];
                lead_waiting = 1'b1;
            end
        end
        if (emit) begin
            if (cp < 21'h80) begin
                add_utf8({1'b0, cp[6:0]}, 1'b0);
            end else if (cp < 21'h800) begin
                add_utf8(Utf8Lead2 | {3'b0, cp[10:6]}, 1'b0);
                add_utf8(Utf8Cont | {2'b0, cp[5:0]}, 1'b0);
            end else if (cp < 21'h10000) begin
                add_utf8(Utf8Lead3 | {4'b0, cp[15:12]}, 1'b0);
                add_utf8(Utf8Cont | {2'b0, cp[11:6]}, 1'b0);
                add_utf8(Utf8Cont | {2'b0, cp[5:0]}, 1'b0);
            end else begin
                add_utf8(Utf8Lead4 | {5'b0, cp[20:18]}, 1'b0);
                add_utf8(Utf8Cont | {2'b0, cp[17:12]}, 1'b0);
                add_utf8(Utf8Cont | {2'b0, cp[11:6]}, 1'b0);
                add_utf8(Utf8Cont | {2'b0, cp[5:0]}, 1'b0);
            end
        end
        if (req.final_byte) begin
            add_utf8(8'h00, 1'b1);
            unit_low = '0;
            unit_low_held = 1'b0;
            lead_payload = '0;
            lead_waiting = 1'b0;
        end
        if (utf8_burst.size() > 0) begin
            utf8_burst[utf8_burst.size() - 1].run_end = 1'b1;
        end
    endtask

    task automatic offer(input script_row_t row);
        u16u8_out_t r;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= row.req;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        transcode_byte(row.req);
        if (row.typed) begin
            for (int k = 0; k < row.n; k++) begin
                r.out_byte = row.utf8[k];
                r.run_end = (k == row.n - 1);
                r.string_end = row.req.final_byte && (k == row.n - 1);
                utf8_expected.push_back(r);
            end
        end else begin
            foreach (utf8_burst[k]) utf8_expected.push_back(utf8_burst[k]);
        end
    endtask

    initial begin : stimulus
        script_row_t row;
        u16u8_in_t   str[$];
        logic [15:0] units[$];
        int unsigned random_bytes;
        int unsigned count;
        random_bytes = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (Script[i]) begin
            offer(Script[i]);
            if (Script[i].req.final_byte) strings_sent++;
        end

        squeeze_req = 1'b1;
        while (random_bytes < RandomItems) begin
            if (random_bytes < RandomItems / 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 62;
            end else if (random_bytes < 2 * RandomItems / 3) begin
                tx_idle_pct = 62;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            str.delete();
            units.delete();
            if ($urandom_range(9) == 0) begin
                // noise: raw bytes, finals anywhere
                count = $urandom_range(5, 1);
                repeat (count) str.push_back({8'($urandom), ($urandom_range(3) == 0)});
            end else begin
                count = $urandom_range(6, 1);
                repeat (count) begin
                    case ($urandom_range(9))
                        0: units.push_back(16'($urandom_range(16'h7f)));
                        1: units.push_back(16'($urandom_range(16'h7ff, 16'h80)));
                        2: units.push_back(16'($urandom_range(16'hd7ff, 16'h800)));
                        3: units.push_back(16'($urandom_range(16'hffff, 16'he000)));
                        4, 5: begin
                            units.push_back(16'($urandom_range(16'hdbff, 16'hd800)));
                            units.push_back(16'($urandom_range(16'hdfff, 16'hdc00)));
                        end
                        6: units.push_back(16'($urandom_range(16'hdfff, 16'hdc00)));
                        7: units.push_back(16'($urandom_range(16'hdbff, 16'hd800)));
                        8: units.push_back(16'h0000);
                        default: units.push_back(16'($urandom));
                    endcase
                end
                case ($urandom_range(3))
                    0: units.push_back(16'($urandom));
                    1: units.push_back(16'($urandom_range(16'hdbff, 16'hd800)));
                    default: ;
                endcase
                foreach (units[k]) begin
                    str.push_back({units[k][7:0], 1'b0});
                    str.push_back({units[k][15:8], 1'b0});
                end
                // odd tail byte
                if ($urandom_range(4) == 0) str.push_back({8'($urandom), 1'b0});
            end
            str[str.size() - 1].final_byte = 1'b1;
            foreach (str[k]) begin
                row = '0;
                row.req = str[k];
                offer(row);
                if (str[k].final_byte) strings_sent++;
            end
            random_bytes += str.size();
        end
        s_valid <= 1'b0;

        while (utf8_expected.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("covered %0d input bytes in %0d strings, %0d output bytes checked",
                 bytes_sent, strings_sent, results_checked);
        $display("boundary code points, surrogate pairs and drops, three idle mixes, one long stall");
        if (mismatches == 0 && utf8_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : receiver
        u16u8_out_t want;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_checked++;
                if (utf8_expected.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected output: byte %02h run_end %0b string_end %0b",
                                 m_data.out_byte, m_data.run_end, m_data.string_end);
                    end
                    mismatches++;
                end else begin
                    want = utf8_expected.pop_front();
                    if (m_data.out_byte !== want.out_byte || m_data.run_end !== want.run_end
                            || m_data.string_end !== want.string_end) begin
                        if (mismatches < 10) begin
                            $display("mismatch at %0t: got %02h/%0b/%0b, expected %02h/%0b/%0b",
                                     $realtime, m_data.out_byte, m_data.run_end,
                                     m_data.string_end, want.out_byte, want.run_end,
                                     want.string_end);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < StallLimit) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no request moved for %0d cycles, %0d outputs outstanding",
                 StallLimit, utf8_expected.size());
        $display("simulation failed");
        $finish;
    end

endmodule
